// ----- rtl/cohbm_pkg.sv -----
// shared types and constants for the canopen heartbeat monitor
package cohbm_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int TABLE_AW    = 7;
  localparam int STATE_W     = 7;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;
  localparam int REG_IDX_W   = 3;
  localparam int ENTRY_W     = 24;

  localparam logic [REG_IDX_W-1:0] REG_OWN_ID = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PERIOD = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COUNT  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ENTRY0 = 3'd3;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_FRAME = 1'b1;

  localparam logic [1:0] EVT_HB_SEND = 2'd0;
  localparam logic [1:0] EVT_GUARD   = 2'd1;
  localparam logic [1:0] EVT_STATE   = 2'd2;
  localparam logic [1:0] EVT_HB_LOST = 2'd3;

  localparam logic [10:0]        HB_BASE         = 11'h700;
  localparam logic [7:0]         TOGGLE_BIT      = 8'h80;
  localparam logic [STATE_W-1:0] ST_UNKNOWN      = 7'h0F;
  localparam logic [STATE_W-1:0] ST_DISCONNECTED = 7'h01;

  typedef struct packed {
    logic        op;
    logic [10:0] frame_id;
    logic        remote_request;
    logic [7:0]  payload_byte;
    logic [6:0]  local_state;
  } cohbm_req_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [6:0]  event_node;
    logic [10:0] tx_id;
    logic [7:0]  tx_byte;
    logic        last;
  } cohbm_rsp_t;

endpackage

// ----- rtl/canopen_heartbeat_monitor_core.sv -----
// canopen heartbeat monitor: node guarding, heartbeat consumer and producer
// path: a beat is held in the item register, its results in the output register
// throughput: one input beat per cycle while rsp_stall is low and each beat yields at
//   most one result; a tick with more than one result (losses plus heartbeat) holds the
//   input until the last is out; the single output register takes one result per cycle
// reset: synchronous; node table valid bits clear at once, so no clearing pass is needed
module canopen_heartbeat_monitor_core
  import cohbm_pkg::*;
#(
  parameter int CONSUMER_SLOTS = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              req_valid,
  output logic              req_stall,
  input  cohbm_req_t        req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output cohbm_rsp_t        rsp
);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [6:0]         own_id;
  logic [15:0]        period;
  logic [2:0]         count;
  logic [ENTRY_W-1:0] entry [CONSUMER_SLOTS];

  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      own_id <= 7'd1;
      period <= '0;
      count  <= '0;
      for (int i = 0; i < CONSUMER_SLOTS; i++) begin
        entry[i] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_idx == REG_OWN_ID) begin
        own_id <= pwdata[6:0];
      end
      if (cfg_idx == REG_PERIOD) begin
        period <= pwdata[15:0];
      end
      if (cfg_idx == REG_COUNT) begin
        count <= pwdata[2:0];
      end
      // slot entries beyond CONSUMER_SLOTS are not stored
      for (int i = 0; i < CONSUMER_SLOTS; i++) begin
        if (cfg_idx == REG_ENTRY0 + REG_IDX_W'(i)) begin
          entry[i] <= pwdata[ENTRY_W-1:0];
        end
      end
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_OWN_ID: prdata = {25'd0, own_id};
      REG_PERIOD: prdata = {16'd0, period};
      REG_COUNT:  prdata = {29'd0, count};
      default: begin
        for (int i = 0; i < CONSUMER_SLOTS; i++) begin
          if (cfg_idx == REG_ENTRY0 + REG_IDX_W'(i)) begin
            prdata = {8'd0, entry[i]};
          end
        end
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // input register and node state table
  // ---------------------------------------------------------------------------
  cohbm_req_t item;
  logic       busy;     // item register holds a beat
  logic       started;  // side effects done, results still to deliver
  logic       accept;
  logic       done;
  logic       first;

  // table: memory with registered read, plus a valid bit per node so that
  // never-written nodes read as unknown
  logic [STATE_W-1:0]  tbl_mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] tbl_valid;
  logic [STATE_W-1:0]  mem_q;
  logic                tbl_we;
  logic [TABLE_AW-1:0] tbl_wa;
  logic [STATE_W-1:0]  tbl_wd;
  // write made at the read edge; the registered read missed it
  logic                fwd_v;
  logic [TABLE_AW-1:0] fwd_a;
  logic [STATE_W-1:0]  fwd_d;

  assign accept    = req_valid && !req_stall;
  assign req_stall = busy && !done;
  assign first     = busy && !started;

  always_ff @(posedge clk) begin
    if (accept) begin
      item  <= req;
      mem_q <= tbl_mem[req.frame_id[TABLE_AW-1:0]];
    end
    if (tbl_we) begin
      tbl_mem[tbl_wa] <= tbl_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tbl_valid <= '0;
      fwd_v     <= 1'b0;
      busy      <= 1'b0;
    end else begin
      if (tbl_we) begin
        tbl_valid[tbl_wa] <= 1'b1;
      end
      fwd_v <= tbl_we;
      if (accept) begin
        busy <= 1'b1;
      end else if (done) begin
        busy <= 1'b0;
      end
    end
    fwd_a <= tbl_wa;
    fwd_d <= tbl_wd;
  end

  // ---------------------------------------------------------------------------
  // per-slot countdown, producer counter, guard toggle
  // ---------------------------------------------------------------------------
  logic [15:0]               slot_rem [CONSUMER_SLOTS];
  logic [CONSUMER_SLOTS-1:0] slot_armed;
  logic [15:0]               producer_count;
  logic                      guard_toggle;

  // first-cycle decode of the held beat
  logic [TABLE_AW-1:0]       nd;
  logic [STATE_W-1:0]        ns;
  logic [STATE_W-1:0]        tbl_cur;
  logic [10:0]               txid;
  logic                      is_tick;
  logic                      hb_frame;
  logic                      guard;
  logic                      chg;
  logic [15:0]               dec [CONSUMER_SLOTS];
  logic [CONSUMER_SLOTS-1:0] expire;
  logic [CONSUMER_SLOTS-1:0] match;
  logic [CONSUMER_SLOTS-1:0] rem_nz;
  logic [15:0]               pc1;
  logic                      fire;
  cohbm_rsp_t                new_frm;

  assign nd       = item.frame_id[TABLE_AW-1:0];
  assign ns       = item.payload_byte[STATE_W-1:0];
  assign txid     = HB_BASE + {4'd0, own_id};
  assign is_tick  = item.op == OP_TICK;
  assign hb_frame = first && !is_tick && !item.remote_request;
  assign guard    = first && !is_tick && item.remote_request && (nd == own_id);
  assign chg      = hb_frame && (tbl_cur != ns);
  assign pc1      = producer_count + 16'd1;
  assign fire     = (period != '0) && ((pc1 >= period) || (pc1 == '0));

  always_comb begin
    if (fwd_v && (fwd_a == nd)) begin
      tbl_cur = fwd_d;
    end else if (tbl_valid[nd]) begin
      tbl_cur = mem_q;
    end else begin
      tbl_cur = ST_UNKNOWN;
    end
  end

  always_comb begin
    for (int i = 0; i < CONSUMER_SLOTS; i++) begin
      dec[i]    = slot_rem[i] - {15'd0, (slot_rem[i] != '0)};
      expire[i] = slot_armed[i] && (dec[i] == '0);
      // only slots in use restart; count above the slot total covers all
      match[i]  = (count > 3'(i)) && (entry[i][23:16] == {1'b0, nd});
      rem_nz[i] = slot_rem[i] != '0;
    end
  end

  always_comb begin
    new_frm = '0;
    if (guard) begin
      new_frm.event_kind = EVT_GUARD;
      new_frm.event_node = own_id;
      new_frm.tx_id      = txid;
      new_frm.tx_byte    = {1'b0, item.local_state} | (guard_toggle ? TOGGLE_BIT : 8'd0);
    end else begin
      new_frm.event_kind = EVT_STATE;
      new_frm.event_node = nd;
      new_frm.tx_byte    = {1'b0, ns};
    end
    new_frm.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CONSUMER_SLOTS; i++) begin
        slot_rem[i] <= '0;
      end
      slot_armed     <= '0;
      producer_count <= '0;
      guard_toggle   <= 1'b0;
    end else begin
      if (first && is_tick) begin
        // every armed slot counts down whatever the slot count says
        for (int i = 0; i < CONSUMER_SLOTS; i++) begin
          if (slot_armed[i]) begin
            slot_rem[i] <= dec[i];
            if (dec[i] == '0) begin
              slot_armed[i] <= 1'b0;
            end
          end
        end
      end
      if (hb_frame && (ns != ST_UNKNOWN)) begin
        // a zero timeout disarms the slot
        for (int i = 0; i < CONSUMER_SLOTS; i++) begin
          if (match[i]) begin
            slot_rem[i]   <= entry[i][15:0];
            slot_armed[i] <= entry[i][15:0] != '0;
          end
        end
      end
      // a period write restarts the producer
      if (cfg_we && (cfg_idx == REG_PERIOD)) begin
        producer_count <= '0;
      end else if (first && is_tick) begin
        producer_count <= fire ? 16'd0 : (period != '0 ? pc1 : 16'd0);
      end
      if (guard) begin
        guard_toggle <= !guard_toggle;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result sequencing: losses in slot order, then heartbeat, or one frame result
  // ---------------------------------------------------------------------------
  logic [CONSUMER_SLOTS-1:0] pend_mask;
  logic                      pend_hb;
  logic                      pend_frm_v;
  cohbm_rsp_t                pend_frm;

  logic [CONSUMER_SLOTS-1:0] eff_mask;
  logic                      eff_hb;
  logic                      eff_frm_v;
  cohbm_rsp_t                eff_frm;
  logic [CONSUMER_SLOTS-1:0] low;
  logic [CONSUMER_SLOTS-1:0] rest_mask;
  logic [ENTRY_W-1:0]        sel_entry;
  logic                      any_res;
  logic                      out_free;
  logic                      emit;
  cohbm_rsp_t                res;

  always_comb begin
    eff_mask  = '0;
    eff_hb    = 1'b0;
    eff_frm_v = 1'b0;
    eff_frm   = new_frm;
    if (started) begin
      eff_mask  = pend_mask;
      eff_hb    = pend_hb;
      eff_frm_v = pend_frm_v;
      eff_frm   = pend_frm;
    end else if (first) begin
      eff_mask  = is_tick ? expire : '0;
      eff_hb    = is_tick && fire;
      eff_frm_v = guard || chg;
    end
  end

  // lowest pending slot, as a one-hot mask
  assign low       = eff_mask & (~eff_mask + CONSUMER_SLOTS'(1));
  assign rest_mask = eff_mask & ~low;

  always_comb begin
    sel_entry = '0;
    for (int i = 0; i < CONSUMER_SLOTS; i++) begin
      if (low[i]) begin
        sel_entry = entry[i];
      end
    end
  end

  always_comb begin
    res = eff_frm;
    if (eff_mask != '0) begin
      res.event_kind = EVT_HB_LOST;
      res.event_node = sel_entry[22:16];
      res.tx_id      = '0;
      res.tx_byte    = {1'b0, ST_DISCONNECTED};
      res.last       = (rest_mask == '0) && !eff_hb;
    end else if (eff_hb) begin
      res.event_kind = EVT_HB_SEND;
      res.event_node = own_id;
      res.tx_id      = txid;
      res.tx_byte    = {1'b0, item.local_state};
      res.last       = 1'b1;
    end
  end

  assign any_res  = (eff_mask != '0) || eff_hb || eff_frm_v;
  assign out_free = !rsp_valid || !rsp_stall;
  assign emit     = any_res && out_free;
  assign done     = busy && (!any_res || (emit && res.last));

  // one table write a cycle: a changed heartbeat state, or a lost node
  // (slot ids above the table size are not written)
  always_comb begin
    tbl_we = 1'b0;
    tbl_wa = nd;
    tbl_wd = ns;
    if (chg) begin
      tbl_we = 1'b1;
    end else if (emit && (eff_mask != '0) && !sel_entry[23]) begin
      tbl_we = 1'b1;
      tbl_wa = sel_entry[22:16];
      tbl_wd = ST_DISCONNECTED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started    <= 1'b0;
      pend_mask  <= '0;
      pend_hb    <= 1'b0;
      pend_frm_v <= 1'b0;
    end else if (busy && !done) begin
      started    <= 1'b1;
      pend_mask  <= emit ? rest_mask : eff_mask;
      pend_hb    <= eff_hb;
      pend_frm_v <= eff_frm_v;
    end else begin
      started <= 1'b0;
    end
    if (first) begin
      pend_frm <= new_frm;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
    if (emit) begin
      rsp <= res;
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_started_has_pending: assert property (@(posedge clk) disable iff (rst)
    started |-> (pend_mask != '0) || pend_hb || pend_frm_v)
    else $error("item held with no results left");

  a_armed_nonzero: assert property (@(posedge clk) disable iff (rst)
    (slot_armed & ~rem_nz) == '0)
    else $error("armed slot with zero remaining time");

  a_producer_bound: assert property (@(posedge clk) disable iff (rst)
    first && is_tick |=> (period == '0) || (producer_count < period))
    else $error("producer count not below period after tick");

  a_guard_toggles: assert property (@(posedge clk) disable iff (rst)
    guard |=> guard_toggle != $past(guard_toggle))
    else $error("guard reply did not flip toggle");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |-> !emit)
    else $error("stalled result overwritten");

endmodule
